// File: sv/uer_pkg.sv
// Shared types, codes and reset values for the ultrasonic echo ranger.
// Used by uer_sensor, uer_result, ultrasonic_echo_ranger and the testbench; depends on nothing.
package uer_pkg;

	localparam int SENSORS_DEF    = 4;
	localparam int COUNT_BITS_DEF = 16;

	// Input item kinds.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_RISE  = 2'd2;
	localparam logic [1:0] KIND_FALL  = 2'd3;

	// Result codes held per sensor slot while results drain.
	localparam logic [1:0] RES_TRIG_RISE = 2'd0;
	localparam logic [1:0] RES_TRIG_FALL = 2'd1;
	localparam logic [1:0] RES_TIMEOUT   = 2'd2;
	localparam logic [1:0] RES_MEASURE   = 2'd3;

	// Status field codes.
	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// Result event codes.
	localparam logic EV_TRIG    = 1'b0;
	localparam logic EV_MEASURE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 3'd5;

	// Configuration reset values.
	localparam logic [3:0]  ENABLED_RST  = 4'd15;
	localparam logic [3:0]  TRIGGER_RST  = 4'd10;
	localparam logic [15:0] TIMEOUT_RST  = 16'd30000;
	localparam logic [15:0] SPEED_RST    = 16'd2248;
	localparam logic [15:0] MIN_DIST_RST = 16'd32;
	localparam logic [15:0] MAX_DIST_RST = 16'd6400;

	// Timing settings that every sensor channel sees.
	typedef struct packed {
		logic [3:0]  trigger_ticks;
		logic [15:0] timeout_ticks;
	} timing_cfg_t;

	// Per-sensor result produced by one accepted item.
	typedef struct packed {
		logic       valid;
		logic [1:0] code;
	} slot_res_t;

endpackage

// File: sv/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger, top level: configuration registers, sensor channels and result stage.
// Results of a transaction are registered and appear in the cycle after it is accepted.
// Throughput: one transaction per cycle while each yields at most one result and out_stall
// is low; a tick that yields several results holds the input until its last is taken.
// Reset (arst_n low, asynchronous): all sensors idle, counters zero, registers at defaults.
// Depends on uer_pkg, uer_sensor, uer_result.
module ultrasonic_echo_ranger #(
	parameter int SENSORS    = uer_pkg::SENSORS_DEF,
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [1:0]                     sensor,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           event_res,
	output logic [1:0]                     unit,
	output logic                           trig_level,
	output logic [1:0]                     status,
	output logic [15:0]                    distance_q4,
	output logic                           last,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);

	// Configuration registers. Writes must arrive only while the block is idle; the block
	// itself does not enforce this, and the channel is always ready.
	logic [3:0]  enabled_mask_q;
	logic [3:0]  trigger_ticks_q;
	logic [15:0] timeout_ticks_q;
	logic [15:0] sound_speed_q;
	logic [15:0] min_dist_q;
	logic [15:0] max_dist_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_mask_q  <= uer_pkg::ENABLED_RST;
			trigger_ticks_q <= uer_pkg::TRIGGER_RST;
			timeout_ticks_q <= uer_pkg::TIMEOUT_RST;
			sound_speed_q   <= uer_pkg::SPEED_RST;
			min_dist_q      <= uer_pkg::MIN_DIST_RST;
			max_dist_q      <= uer_pkg::MAX_DIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				uer_pkg::REG_ENABLED:  enabled_mask_q  <= cfg_data[3:0];
				uer_pkg::REG_TRIGGER:  trigger_ticks_q <= cfg_data[3:0];
				uer_pkg::REG_TIMEOUT:  timeout_ticks_q <= cfg_data;
				uer_pkg::REG_SPEED:    sound_speed_q   <= cfg_data;
				uer_pkg::REG_MIN_DIST: min_dist_q      <= cfg_data;
				uer_pkg::REG_MAX_DIST: max_dist_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake. A transaction is taken whenever the result stage is empty
	// or is handing over its final pending result in this cycle.
	logic in_accept, can_load, is_tick, addr_enabled;

	assign in_stall     = !can_load;
	assign in_accept    = in_valid && !in_stall;
	assign is_tick      = kind == uer_pkg::KIND_TICK;
	assign addr_enabled = enabled_mask_q[sensor];

	uer_pkg::timing_cfg_t  timing;
	uer_pkg::slot_res_t    slot_res [SENSORS];
	logic [COUNT_BITS-1:0] echo_cnt [SENSORS];
	logic [COUNT_BITS-1:0] echo_sel;

	assign timing.trigger_ticks = trigger_ticks_q;
	assign timing.timeout_ticks = timeout_ticks_q;

	// Each sensor updates its own state in the cycle a transaction is accepted.
	// Sensors beyond the reach of the sensor field only ever see ticks.
	for (genvar g = 0; g < SENSORS; g++) begin : g_sensor
		logic hit;
		assign hit = in_accept && !is_tick && addr_enabled && (32'(sensor) == g);

		uer_sensor #(
			.COUNT_BITS(COUNT_BITS)
		) u_sensor (
			.clk        (clk),
			.arst_n     (arst_n),
			.tick       (in_accept && is_tick),
			.hit        (hit),
			.kind       (kind),
			.timing     (timing),
			.res        (slot_res[g]),
			.echo_count (echo_cnt[g])
		);
	end

	// Echo count of the addressed sensor feeds the distance multiplier.
	always_comb begin
		echo_sel = '0;
		for (int i = 0; i < SENSORS; i++) begin
			if (32'(sensor) == i) begin
				echo_sel = echo_cnt[i];
			end
		end
	end

	uer_result #(
		.SENSORS    (SENSORS),
		.COUNT_BITS (COUNT_BITS)
	) u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (in_accept),
		.slot_res        (slot_res),
		.echo_sel        (echo_sel),
		.sound_speed_q16 (sound_speed_q),
		.min_distance_q4 (min_dist_q),
		.max_distance_q4 (max_dist_q),
		.can_load        (can_load),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_res       (event_res),
		.unit            (unit),
		.trig_level      (trig_level),
		.status          (status),
		.distance_q4     (distance_q4),
		.last            (last)
	);

endmodule

// File: sv/uer_sensor.sv
// One sensor channel of the echo ranger: phase and counters, updated per transaction.
// Depends on uer_pkg.
module uer_sensor #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick,      // accepted tick transaction
	input  logic                    hit,       // accepted start/edge for this enabled sensor
	input  logic [1:0]              kind,
	input  uer_pkg::timing_cfg_t    timing,
	output uer_pkg::slot_res_t      res,
	output logic [COUNT_BITS-1:0]   echo_count
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TRIG = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_ECHO = 2'd3;

	logic [1:0]            phase_q, phase_d;
	logic [3:0]            trig_q, trig_d, trig_inc;
	logic [15:0]           wait_q, wait_d;
	logic [COUNT_BITS-1:0] echo_q, echo_d;

	assign trig_inc   = trig_q + 4'd1;
	assign echo_count = echo_q;

	always_comb begin
		phase_d   = phase_q;
		trig_d    = trig_q;
		wait_d    = wait_q;
		echo_d    = echo_q;
		res.valid = 1'b0;
		res.code  = uer_pkg::RES_TRIG_RISE;
		if (tick) begin
			unique case (phase_q)
				PH_TRIG: begin
					trig_d = trig_inc;
					if (trig_inc >= timing.trigger_ticks || trig_inc == 4'd0) begin
						phase_d   = PH_WAIT;
						wait_d    = '0;
						res.valid = 1'b1;
						res.code  = uer_pkg::RES_TRIG_FALL;
					end
				end
				PH_WAIT, PH_ECHO: begin
					if (wait_q >= timing.timeout_ticks) begin
						phase_d   = PH_IDLE;
						res.valid = 1'b1;
						res.code  = uer_pkg::RES_TIMEOUT;
					end else begin
						wait_d = wait_q + 16'd1;
						if (phase_q == PH_ECHO && echo_q != '1) begin
							echo_d = echo_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end else if (hit) begin
			case (kind)
				uer_pkg::KIND_START: begin
					phase_d = PH_TRIG;
					trig_d  = '0;
					wait_d  = '0;
					echo_d  = '0;
					if (phase_q != PH_TRIG) begin
						res.valid = 1'b1;
						res.code  = uer_pkg::RES_TRIG_RISE;
					end
				end
				uer_pkg::KIND_RISE: begin
					if (phase_q == PH_WAIT || phase_q == PH_ECHO) begin
						phase_d = PH_ECHO;
						echo_d  = '0;
					end
				end
				uer_pkg::KIND_FALL: begin
					if (phase_q == PH_ECHO) begin
						phase_d   = PH_IDLE;
						res.valid = 1'b1;
						res.code  = uer_pkg::RES_MEASURE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			trig_q  <= '0;
			wait_q  <= '0;
			echo_q  <= '0;
		end else begin
			phase_q <= phase_d;
			trig_q  <= trig_d;
			wait_q  <= wait_d;
			echo_q  <= echo_d;
		end
	end

endmodule

// File: sv/uer_result.sv
// Result register of the echo ranger: holds the results of one transaction and
// delivers them in ascending sensor order. Depends on uer_pkg.
module uer_result #(
	parameter int SENSORS    = uer_pkg::SENSORS_DEF,
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  uer_pkg::slot_res_t      slot_res [SENSORS],
	input  logic [COUNT_BITS-1:0]   echo_sel,
	input  logic [15:0]             sound_speed_q16,
	input  logic [15:0]             min_distance_q4,
	input  logic [15:0]             max_distance_q4,
	output logic                    can_load,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    event_res,
	output logic [1:0]              unit,
	output logic                    trig_level,
	output logic [1:0]              status,
	output logic [15:0]             distance_q4,
	output logic                    last
);

	localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int PROD_W = COUNT_BITS + 16;
	localparam int D_W    = PROD_W - 13;
	localparam int CMP_W  = (D_W > 16) ? D_W : 16;

	logic [SENSORS-1:0] pend_q, pend_load, cur_hot;
	logic [1:0]         code_q [SENSORS];
	logic [D_W-1:0]     dist_q;
	logic [PROD_W-1:0]  prod;
	logic [IDX_W-1:0]   cur_idx;
	logic [1:0]         cur_code;
	logic [CMP_W-1:0]   d_ext, min_ext, max_ext;
	logic               out_of_range, take;

	// The distance product is registered; range checks happen on the output side.
	assign prod = PROD_W'(echo_sel) * PROD_W'(sound_speed_q16);

	always_comb begin
		for (int i = 0; i < SENSORS; i++) begin
			pend_load[i] = slot_res[i].valid;
		end
	end

	// Lowest pending sensor goes first.
	always_comb begin
		cur_idx = '0;
		cur_hot = '0;
		for (int i = SENSORS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				cur_idx = IDX_W'(i);
				cur_hot = '0;
				cur_hot[i] = 1'b1;
			end
		end
	end

	assign cur_code  = code_q[cur_idx];
	assign out_valid = |pend_q;
	assign last      = (pend_q & ~cur_hot) == '0;
	assign take      = out_valid && !out_stall;
	assign can_load  = !out_valid || (take && last);

	assign d_ext        = CMP_W'(dist_q);
	assign min_ext      = CMP_W'(min_distance_q4);
	assign max_ext      = CMP_W'(max_distance_q4);
	assign out_of_range = (d_ext < min_ext) || (d_ext > max_ext);

	always_comb begin
		unit        = 2'(cur_idx);
		event_res   = uer_pkg::EV_TRIG;
		trig_level  = 1'b0;
		status      = uer_pkg::ST_VALID;
		distance_q4 = '0;
		case (cur_code)
			uer_pkg::RES_TRIG_RISE: trig_level = 1'b1;
			uer_pkg::RES_TRIG_FALL: trig_level = 1'b0;
			uer_pkg::RES_TIMEOUT: begin
				event_res = uer_pkg::EV_MEASURE;
				status    = uer_pkg::ST_TIMEOUT;
			end
			default: begin
				event_res = uer_pkg::EV_MEASURE;
				if (out_of_range) begin
					status = uer_pkg::ST_RANGE;
				end else if (d_ext > CMP_W'(16'hFFFF)) begin
					distance_q4 = 16'hFFFF;
				end else begin
					distance_q4 = d_ext[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= pend_load;
		end else if (take) begin
			pend_q <= pend_q & ~cur_hot;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dist_q <= prod[PROD_W-1:13];
			for (int i = 0; i < SENSORS; i++) begin
				code_q[i] <= slot_res[i].code;
			end
		end
	end

endmodule

// File: dv/tb_ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_echo_ranger: directed and random ranging traffic,
// predicted per sensor by a scoreboard class. Depends on uer_pkg and the ranger RTL.

import uer_pkg::*;

// One result transaction as it appears on the output ports.
typedef struct {
	logic        ev;
	logic [1:0]  unit;
	logic        lvl;
	logic [1:0]  status;
	logic [15:0] dist_q4;
	logic        last;
} echo_result_t;

// Per-sensor measurement phase.
typedef enum logic [1:0] {
	PH_IDLE = 2'd0,
	PH_TRIG = 2'd1,
	PH_WAIT = 2'd2,
	PH_ECHO = 2'd3
} sensor_phase_t;

// Tracks the four sensor channels and the register file, and holds the results still owed.
class echo_scoreboard;
	logic [3:0]    enabled;
	logic [3:0]    trig_len;
	logic [15:0]   timeout_len;
	logic [15:0]   speed;
	logic [15:0]   dist_min;
	logic [15:0]   dist_max;
	sensor_phase_t phase [4];
	logic [3:0]    trig_cnt [4];
	logic [15:0]   wait_cnt [4];
	logic [15:0]   echo_cnt [4];
	echo_result_t  awaited [$];
	int            errors;
	int            matched;
	int            n_valid;
	int            n_range;
	int            n_timeout;

	function new();
		enabled     = ENABLED_RST;
		trig_len    = TRIGGER_RST;
		timeout_len = TIMEOUT_RST;
		speed       = SPEED_RST;
		dist_min    = MIN_DIST_RST;
		dist_max    = MAX_DIST_RST;
		for (int i = 0; i < 4; i++) begin
			phase[i]    = PH_IDLE;
			trig_cnt[i] = '0;
			wait_cnt[i] = '0;
			echo_cnt[i] = '0;
		end
		errors    = 0;
		matched   = 0;
		n_valid   = 0;
		n_range   = 0;
		n_timeout = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			REG_ENABLED:  enabled     = val[3:0];
			REG_TRIGGER:  trig_len    = val[3:0];
			REG_TIMEOUT:  timeout_len = val;
			REG_SPEED:    speed       = val;
			REG_MIN_DIST: dist_min    = val;
			REG_MAX_DIST: dist_max    = val;
			default: ;
		endcase
	endfunction

	function void add(logic ev, logic [1:0] u, logic lvl, logic [1:0] st, logic [15:0] d);
		echo_result_t r;
		r.ev      = ev;
		r.unit    = u;
		r.lvl     = lvl;
		r.status  = st;
		r.dist_q4 = d;
		r.last    = 1'b0;
		awaited.push_back(r);
	endfunction

	// Works out the results of one accepted input transaction.
	function void note_item(logic [1:0] k, logic [1:0] s);
		int          first;
		logic [31:0] prod;
		logic [18:0] d;
		logic [1:0]  st;
		logic [15:0] dq;
		echo_result_t r;
		first = awaited.size();
		if (k == KIND_TICK) begin
			for (int i = 0; i < 4; i++) begin
				case (phase[i])
					PH_TRIG: begin
						trig_cnt[i] = trig_cnt[i] + 4'd1;
						if (trig_cnt[i] >= trig_len || trig_cnt[i] == 4'd0) begin
							phase[i]    = PH_WAIT;
							wait_cnt[i] = '0;
							add(EV_TRIG, 2'(i), 1'b0, ST_VALID, 16'd0);
						end
					end
					PH_WAIT, PH_ECHO: begin
						if (wait_cnt[i] >= timeout_len) begin
							phase[i] = PH_IDLE;
							add(EV_MEASURE, 2'(i), 1'b0, ST_TIMEOUT, 16'd0);
							n_timeout++;
						end else begin
							wait_cnt[i] = wait_cnt[i] + 16'd1;
							if (phase[i] == PH_ECHO && echo_cnt[i] != 16'hFFFF)
								echo_cnt[i] = echo_cnt[i] + 16'd1;
						end
					end
					default: ;
				endcase
			end
		end else if (enabled[s]) begin
			case (k)
				KIND_START: begin
					if (phase[s] != PH_TRIG)
						add(EV_TRIG, s, 1'b1, ST_VALID, 16'd0);
					phase[s]    = PH_TRIG;
					trig_cnt[s] = '0;
					wait_cnt[s] = '0;
					echo_cnt[s] = '0;
				end
				KIND_RISE: begin
					if (phase[s] == PH_WAIT || phase[s] == PH_ECHO) begin
						phase[s]    = PH_ECHO;
						echo_cnt[s] = '0;
					end
				end
				KIND_FALL: begin
					if (phase[s] == PH_ECHO) begin
						prod = 32'(echo_cnt[s]) * 32'(speed);
						d    = prod[31:13];
						if (d < 19'(dist_min) || d > 19'(dist_max)) begin
							st = ST_RANGE;
							dq = 16'd0;
							n_range++;
						end else begin
							st = ST_VALID;
							dq = (d > 19'd65535) ? 16'hFFFF : d[15:0];
							n_valid++;
						end
						phase[s] = PH_IDLE;
						add(EV_MEASURE, s, 1'b0, st, dq);
					end
				end
				default: ;
			endcase
		end
		if (awaited.size() > first) begin
			r = awaited.pop_back();
			r.last = 1'b1;
			awaited.push_back(r);
		end
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(echo_result_t got);
		echo_result_t want;
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual event %0d unit %0d",
				$time, got.ev, got.unit);
			return;
		end
		want = awaited.pop_front();
		compare_field("event_res", want.ev, got.ev);
		compare_field("unit", want.unit, got.unit);
		compare_field("trig_level", want.lvl, got.lvl);
		compare_field("status", want.status, got.status);
		compare_field("distance_q4", want.dist_q4, got.dist_q4);
		compare_field("last", want.last, got.last);
		matched++;
	endfunction
endclass

module tb_ultrasonic_echo_ranger;

	// Clock and reset. The period is 4 ns; stimulus moves on the falling edge so that
	// every port the block samples is settled well before the rising edge.
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Input channel.
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           kind;
	logic [1:0]           sensor;
	// Result channel.
	logic                 out_valid;
	logic                 out_stall;
	logic                 event_res;
	logic [1:0]           unit;
	logic                 trig_level;
	logic [1:0]           status;
	logic [15:0]          distance_q4;
	logic                 last;
	// Configuration write channel.
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	ultrasonic_echo_ranger DUT (.*);

	echo_scoreboard sb;

	// Percent chance per cycle that the sender holds back or the receiver stalls.
	int idle_pct;
	int stall_pct;
	int items_sent;
	int settings_used;
	int kind_seen [4];

	// The receiver decides its stall on every falling edge, so stalls land on any
	// cycle of a multi-result tick as well as between transactions.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Every result transaction is checked on the edge where it is taken.
	always @(posedge clk) begin
		echo_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.ev      = event_res;
			got.unit    = unit;
			got.lvl     = trig_level;
			got.status  = status;
			got.dist_q4 = distance_q4;
			got.last    = last;
			sb.check_result(got);
		end
	end

	// Offers one input transaction after an optional random gap and holds it until
	// the block takes it. in_valid is left high; the next call or a drain decides
	// its value at the following falling edge, so it is assigned once per step.
	task automatic send_item(input logic [1:0] k, input logic [1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		sensor   <= s;
		do @(posedge clk); while (in_stall);
		sb.note_item(k, s);
		items_sent++;
		kind_seen[k]++;
	endtask

	// Ticks carry a random sensor field, which the block must ignore.
	task automatic send_ticks(input int n);
		repeat (n) send_item(KIND_TICK, 2'($urandom));
	endtask

	// Stops offering input and waits until every owed result has come out, then waits
	// out any transaction that produced no result but is still in flight.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write transaction; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Loads a full register setting once the block has gone quiet.
	task automatic write_setting(input logic [15:0] mask, input logic [15:0] trig,
			input logic [15:0] tmo, input logic [15:0] spd,
			input logic [15:0] dmin, input logic [15:0] dmax);
		wait_drain();
		write_reg(REG_ENABLED, mask);
		write_reg(REG_TRIGGER, trig);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_SPEED, spd);
		write_reg(REG_MIN_DIST, dmin);
		write_reg(REG_MAX_DIST, dmax);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// A typical ranging cycle on one sensor with random timing: start, some ticks
	// while the trigger is high or the echo is awaited, the echo pulse, and its end.
	// Now and then a step is dropped or the echo rises twice, which leaves sensors
	// busy so that later ticks find several of them in flight.
	task automatic run_measurement(input int pulse_max);
		logic [1:0] s;
		int         n;
		s = 2'($urandom_range(3));
		n = $urandom_range(int'(sb.trig_len) + 2);
		send_item(KIND_START, s);
		send_ticks(n);
		if ($urandom_range(9) != 0)
			send_item(KIND_RISE, s);
		send_ticks($urandom_range(pulse_max));
		if ($urandom_range(9) == 0) begin
			send_item(KIND_RISE, s);
			send_ticks($urandom_range(3));
		end
		if ($urandom_range(9) != 0)
			send_item(KIND_FALL, s);
	endtask

	// Mostly well-formed measurements, the rest single random transactions. Halfway
	// through, the sender waits until every result owed so far has arrived.
	task automatic run_random_phase(input int idle, input int stall, input int target,
			input int pulse_max);
		int start_count;
		bit held;
		idle_pct    = idle;
		stall_pct   = stall;
		start_count = items_sent;
		held        = 1'b0;
		while (items_sent - start_count < target) begin
			if (!held && items_sent - start_count >= target / 2) begin
				wait_drain();
				held = 1'b1;
			end
			if ($urandom_range(9) < 7)
				run_measurement(pulse_max);
			else
				send_item(2'($urandom), 2'($urandom));
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_TICK;
		sensor        = 2'd0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ENABLED;
		cfg_data      = 16'd0;
		idle_pct      = 0;
		stall_pct     = 0;
		items_sent    = 0;
		settings_used = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A start on sensor 3 under the reset settings shows that it comes up enabled.
		send_item(KIND_START, 2'd3);

		// Directed part: a two-tick trigger and a three-tick timeout keep the
		// sequences short enough to walk through every phase by hand.
		write_setting(16'd15, 16'd2, 16'd3, 16'd65535, 16'd0, 16'd65535);
		send_item(KIND_START, 2'd0);
		// A second start while the trigger is still high restarts silently.
		send_item(KIND_START, 2'd0);
		// Echo edges while the trigger is high are both ignored.
		send_item(KIND_RISE, 2'd0);
		send_item(KIND_FALL, 2'd0);
		send_item(KIND_START, 2'd1);
		send_item(KIND_START, 2'd2);
		send_item(KIND_START, 2'd3);
		// All four triggers fall on the same tick, in ascending sensor order.
		send_ticks(2);
		send_item(KIND_RISE, 2'd0);
		send_item(KIND_RISE, 2'd3);
		send_ticks(1);
		// A repeated rise restarts the pulse timer of sensor 0.
		send_item(KIND_RISE, 2'd0);
		send_ticks(1);
		send_item(KIND_FALL, 2'd0);
		// A stray falling edge on an idle sensor does nothing.
		send_item(KIND_FALL, 2'd0);
		send_item(KIND_RISE, 2'd1);
		send_ticks(1);
		send_item(KIND_START, 2'd0);
		// Sensors 1 to 3 time out together while sensor 0 has its trigger high.
		send_ticks(2);

		// With every sensor disabled, starts and edges are ignored, yet the busy
		// sensor 0 keeps counting and still times out.
		wait_drain();
		write_reg(REG_ENABLED, 16'd0);
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_item(KIND_START, 2'd1);
		send_item(KIND_RISE, 2'd0);
		send_ticks(4);

		// Random part, one register setting per phase of idling.
		write_setting(16'd15, 16'd1, 16'd20, 16'd40000, 16'd10, 16'd300);
		run_random_phase(0, 0, 18, 30);
		// Longest trigger, the longest timeout, the slowest nonzero speed.
		write_setting(16'd11, 16'd15, 16'd65535, 16'd1, 16'd0, 16'd0);
		run_random_phase(82, 0, 18, 40);
		// Zero trigger length and zero timeout: both end on the first tick.
		write_setting(16'd6, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535);
		run_random_phase(0, 82, 14, 2);
		// Crossed range limits put every measurement out of range.
		write_setting(16'd15, 16'd3, 16'd30, 16'd20000, 16'd300, 16'd100);
		run_random_phase(10, 10, 15, 25);
		// Back to the reset values, with no idling.
		write_setting(16'd15, 16'd10, 16'd30000, 16'd2248, 16'd32, 16'd6400);
		run_random_phase(0, 0, 15, 40);

		wait_drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d transactions (%0d ticks, %0d starts, %0d rises, %0d falls)",
			items_sent, kind_seen[KIND_TICK], kind_seen[KIND_START],
			kind_seen[KIND_RISE], kind_seen[KIND_FALL]);
		$display("over %0d settings; %0d results: %0d valid, %0d out of range, %0d timeouts.",
			settings_used, sb.matched, sb.n_valid, sb.n_range, sb.n_timeout);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
sv/uer_pkg.sv
sv/uer_sensor.sv
sv/uer_result.sv
sv/ultrasonic_echo_ranger.sv
dv/tb_ultrasonic_echo_ranger.sv
